// ----- rtl/lmp_pkg.sv -----
// Shared types, constants and helpers of the look-at perspective projection block.
package lmp_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    // Unit vectors are Q2.28 in 30 signed bits
    localparam int UNIT_BITS = 28;
    localparam int UNIT_W    = 30;
    localparam int NORM_BITS = 30;

    localparam int FOCAL    = 300;
    localparam int CENTER_X = 640;
    localparam int CENTER_Y = 360;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_ZERO  = 2'd1;
    localparam t_status ST_DEGEN = 2'd2;
    localparam t_status ST_SAT   = 2'd3;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_CAM_X  = 3'd0;
    localparam t_reg_idx REG_CAM_Y  = 3'd1;
    localparam t_reg_idx REG_CAM_Z  = 3'd2;
    localparam t_reg_idx REG_LOOK_X = 3'd3;
    localparam t_reg_idx REG_LOOK_Y = 3'd4;
    localparam t_reg_idx REG_LOOK_Z = 3'd5;

    typedef logic signed [UNIT_W-1:0] t_unit;

    // Camera basis handed from the basis unit to the point pipeline
    typedef struct packed {
        t_unit [2:0] f;
        t_unit [2:0] r;
        t_unit [2:0] u;
        logic        degen;
        logic        ready;
    } t_basis;

    // Side information that travels with a word through the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
    } t_tag;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SCALE,
        BS_SQUARE,
        BS_SQRT,
        BS_DLOAD,
        BS_DIV,
        BS_UMUL,
        BS_UACC
    } t_bstate;

    function automatic int max2(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Screen center clamped to the signed coordinate range
    function automatic logic signed [63:0] center_sat(int w, int f, int c);
        logic signed [63:0] v;
        logic signed [63:0] hi;
        v  = 64'(c) <<< f;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        if (v > hi) return hi;
        if (v < -hi - 64'sd1) return -hi - 64'sd1;
        return v;
    endfunction

endpackage

// ----- rtl/lmp_basis.sv -----
// Sequential camera basis unit: normalizes forward and right, then forms up.
module lmp_basis import lmp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2:0][COORD_WIDTH-1:0] i_cam,
    input  logic [2:0][COORD_WIDTH-1:0] i_look,
    output t_basis                      o_basis
);

    localparam int DW  = COORD_WIDTH + 1;
    localparam int SHW = 6;

    t_bstate r_state, n_state;

    logic                     r_pend;
    logic                     r_phase;
    logic                     r_degen;
    logic [1:0]               r_ci;
    logic [1:0]               r_k;
    logic [UNIT_W-1:0]        r_m [3];
    logic                     r_neg [3];
    logic [63:0]              r_sum;
    logic [63:0]              r_res;
    logic [63:0]              r_bit;
    logic [31:0]              r_len;
    logic [63:0]              r_num;
    logic [31:0]              r_rem;
    logic [31:0]              r_q;
    logic [5:0]               r_cnt;
    logic signed [59:0]       r_prod;
    logic signed [60:0]       r_acc;
    t_unit                    r_f [3];
    t_unit                    r_r [3];
    t_unit                    r_u [3];

    logic signed [DW-1:0]     w_d   [3];
    logic signed [DW-1:0]     w_vec [3];
    logic [DW-1:0]            w_mag [3];
    logic [63:0]              w_orm;
    logic [SHW-1:0]           w_shift;
    logic                     w_degen;
    logic [63:0]              w_sq_t;
    logic                     w_sq_ge;
    logic [32:0]              w_rem2;
    logic                     w_div_ge;
    logic [31:0]              w_qfin;
    t_unit                    w_qval;
    t_unit                    w_ma, w_mb;

    // Round Q56 to Q28, halves up
    function automatic t_unit rnd_u(logic signed [61:0] x);
        logic signed [61:0] y;
        y = (x + (62'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
        return UNIT_W'(y);
    endfunction

    // Direction vector and its scaled magnitudes
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = $signed({i_look[i][COORD_WIDTH-1], i_look[i]})
                   - $signed({i_cam[i][COORD_WIDTH-1], i_cam[i]});
        end
        if (!r_phase) begin
            w_vec[0] = w_d[0];
            w_vec[1] = w_d[1];
            w_vec[2] = w_d[2];
        end else begin
            w_vec[0] = -w_d[2];
            w_vec[1] = '0;
            w_vec[2] = w_d[0];
        end
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_vec[i][DW-1] ? DW'(-w_vec[i]) : DW'(w_vec[i]);
        end
        w_orm   = 64'(w_mag[0] | w_mag[1] | w_mag[2]);
        w_shift = '0;
        for (int k = 0; k < DW; k++) begin
            if ((w_orm >> k) >= (64'd1 << NORM_BITS)) w_shift = SHW'(k + 1);
        end
        w_degen = (w_d[0] == '0) && (w_d[2] == '0);
    end

    // One square-root step and one divide step
    always_comb begin
        w_sq_t   = r_res + r_bit;
        w_sq_ge  = (r_sum >= w_sq_t);
        w_rem2   = {r_rem, r_num[63]};
        w_div_ge = (w_rem2 >= {1'b0, r_len});
        w_qfin   = {r_q[30:0], w_div_ge};
        w_qval   = r_neg[r_ci] ? -$signed(UNIT_W'(w_qfin)) : $signed(UNIT_W'(w_qfin));
    end

    // Cross-product operand select
    always_comb begin
        unique case (r_k)
            2'd0:    begin w_ma = r_r[2]; w_mb = r_f[1]; end
            2'd1:    begin w_ma = r_r[2]; w_mb = r_f[0]; end
            2'd2:    begin w_ma = r_r[0]; w_mb = r_f[2]; end
            default: begin w_ma = r_r[0]; w_mb = r_f[1]; end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance sequencer
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = BS_IDLE;
        end else begin
            unique case (r_state)
                BS_IDLE:   if (r_pend && !w_degen) n_state = BS_SCALE;
                BS_SCALE:  n_state = BS_SQUARE;
                BS_SQUARE: if (r_k == 2'd2) n_state = BS_SQRT;
                BS_SQRT:   if (r_bit == '0) n_state = BS_DLOAD;
                BS_DLOAD:  n_state = BS_DIV;
                BS_DIV: begin
                    if (r_cnt == '1) begin
                        if (r_ci != 2'd2)  n_state = BS_DLOAD;
                        else if (!r_phase) n_state = BS_SCALE;
                        else               n_state = BS_UMUL;
                    end
                end
                BS_UMUL:   n_state = BS_UACC;
                BS_UACC:   n_state = (r_k == 2'd3) ? BS_IDLE : BS_UMUL;
                default:   n_state = BS_IDLE;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b1;
            r_phase <= 1'b0;
            r_degen <= 1'b0;
            r_ci    <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_pend <= 1'b1;
        end else begin
            unique case (r_state)
                BS_IDLE: begin
                    if (r_pend) begin
                        r_pend  <= 1'b0;
                        r_degen <= w_degen;
                        r_phase <= 1'b0;
                    end
                end
                BS_SCALE:  r_k <= '0;
                BS_SQUARE: r_k <= r_k + 2'd1;
                BS_SQRT:   r_ci <= '0;
                BS_DLOAD:  r_cnt <= '0;
                BS_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == '1) begin
                        if (r_ci != 2'd2) begin
                            r_ci <= r_ci + 2'd1;
                        end else if (!r_phase) begin
                            r_phase <= 1'b1;
                        end else begin
                            r_k <= '0;
                        end
                    end
                end
                BS_UMUL:   r_k <= r_k;
                BS_UACC:   r_k <= r_k + 2'd1;
                default:   r_k <= r_k;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= UNIT_W'(64'(w_mag[i]) >> w_shift);
                    r_neg[i] <= w_vec[i][DW-1];
                end
                r_sum <= '0;
            end
            BS_SQUARE: begin
                r_sum <= r_sum + 64'(r_m[r_k]) * 64'(r_m[r_k]);
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            BS_SQRT: begin
                if (r_bit != '0) begin
                    if (w_sq_ge) begin
                        r_sum <= r_sum - w_sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_len <= (r_res == '0) ? 32'd1 : r_res[31:0];
                end
            end
            BS_DLOAD: begin
                r_num <= (64'(r_m[r_ci]) << UNIT_BITS) + 64'(r_len >> 1);
                r_rem <= '0;
                r_q   <= '0;
            end
            BS_DIV: begin
                r_rem <= w_div_ge ? 32'(w_rem2 - {1'b0, r_len}) : w_rem2[31:0];
                r_num <= r_num << 1;
                r_q   <= w_qfin;
                if (r_cnt == '1) begin
                    if (!r_phase) r_f[r_ci] <= w_qval;
                    else          r_r[r_ci] <= w_qval;
                end
            end
            BS_UMUL: r_prod <= w_ma * w_mb;
            BS_UACC: begin
                unique case (r_k)
                    2'd0:    r_u[0] <= rnd_u(-62'(r_prod));
                    2'd1:    r_acc  <= 61'(r_prod);
                    2'd2:    r_u[1] <= rnd_u(62'(r_acc) - 62'(r_prod));
                    default: r_u[2] <= rnd_u(62'(r_prod));
                endcase
            end
            default: r_acc <= r_acc;
        endcase
    end

    // Drive basis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_basis.f[i] = r_f[i];
            o_basis.r[i] = r_r[i];
            o_basis.u[i] = r_u[i];
        end
        o_basis.degen = r_degen;
        o_basis.ready = (r_state == BS_IDLE) && !r_pend;
    end

endmodule

// ----- rtl/lmp_div.sv -----
// Pipelined restoring divider, two numerator lanes over one shared divisor.
module lmp_div import lmp_pkg::*; #(
    parameter int NUMW = 48,
    parameter int DENW = 27,
    parameter int QB   = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [NUMW-1:0] i_num_x,
    input  logic [NUMW-1:0] i_num_y,
    input  logic [DENW-1:0] i_den,
    input  t_tag            i_tag,
    output logic            o_vld,
    output logic [QB-1:0]   o_q_x,
    output logic [QB-1:0]   o_q_y,
    output t_tag            o_tag
);

    localparam int RW   = DENW + QB;
    localparam int CMPW = max2(NUMW, RW) + 1;

    logic            r_vld   [QB+1];
    logic [RW-1:0]   r_rem_x [QB+1];
    logic [RW-1:0]   r_rem_y [QB+1];
    logic [QB-1:0]   r_q_x   [QB+1];
    logic [QB-1:0]   r_q_y   [QB+1];
    logic [DENW-1:0] r_den   [QB+1];
    t_tag            r_tag   [QB+1];
    logic            r_ovf_x [QB+1];
    logic            r_ovf_y [QB+1];

    logic [CMPW-1:0] w_lim;

    assign w_lim = CMPW'(i_den) << QB;

    // Load: flag quotients that overflow the quotient width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x[0] <= RW'(i_num_x);
            r_rem_y[0] <= RW'(i_num_y);
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_den[0]   <= i_den;
            r_tag[0]   <= i_tag;
            r_ovf_x[0] <= (CMPW'(i_num_x) >= w_lim);
            r_ovf_y[0] <= (CMPW'(i_num_y) >= w_lim);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int B = QB - 1 - k;
        logic [RW-1:0] w_sub;
        logic          w_ge_x;
        logic          w_ge_y;

        assign w_sub  = RW'(r_den[k]) << B;
        assign w_ge_x = (r_rem_x[k] >= w_sub);
        assign w_ge_y = (r_rem_y[k] >= w_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[k+1] <= w_ge_x ? r_rem_x[k] - w_sub : r_rem_x[k];
                r_rem_y[k+1] <= w_ge_y ? r_rem_y[k] - w_sub : r_rem_y[k];
                r_q_x[k+1]   <= r_q_x[k] | (QB'(w_ge_x) << B);
                r_q_y[k+1]   <= r_q_y[k] | (QB'(w_ge_y) << B);
                r_den[k+1]   <= r_den[k];
                r_tag[k+1]   <= r_tag[k];
                r_ovf_x[k+1] <= r_ovf_x[k];
                r_ovf_y[k+1] <= r_ovf_y[k];
            end
        end
    end

    // Clamp overflowed quotients to all ones
    assign o_vld = r_vld[QB];
    assign o_q_x = r_ovf_x[QB] ? '1 : r_q_x[QB];
    assign o_q_y = r_ovf_y[QB] ? '1 : r_q_y[QB];
    assign o_tag = r_tag[QB];

endmodule

// ----- rtl/lookat_perspective_project.sv -----
// Look-at perspective projection: world point stream in, screen point stream out.
//
// Input stream: one world point per word (x, y, z signed fixed point). Output
// stream: screen x and y in tdata, status in tuser (ok, zero depth, degenerate
// camera, saturated). The config port writes camera position and look target.
//
// Throughput is one point per cycle while the receiver takes words and the basis
// is ready. The pipeline is five front stages (offset, basis products, dot sums,
// focal scale, rounding bias), a divider of one stage per quotient bit plus a
// load stage (QB + 1, QB = max(COORD_WIDTH + 1, FRAC_BITS + 11) + 1), and the
// output register.
//
// After reset and after every config write the basis unit rebuilds the camera
// basis (two vector normalizations through a shared square root and a shared
// bit-serial divider, then the up vector), and the input tready stays low meanwhile;
// when the camera is degenerate no rebuild runs and tready drops only while it is pending.
//
// A stalled receiver freezes the whole pipeline, output register included, so
// no word is lost or repeated; tready on the input follows the output stall.
module lookat_perspective_project import lmp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // screen_x, screen_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    // status
    output t_status                                 o_m_axis_tuser,
    input  logic                                    i_cfg_we,
    input  t_reg_idx                                i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]                  i_cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int TDO  = ((2*W+7)/8)*8;
    localparam int RELW = W + 1;
    localparam int PW   = RELW + UNIT_W;
    localparam int SUMW = PW + 2;
    localparam int VW   = W + 3;
    localparam int KW   = F + 9;
    localparam int NW   = VW + KW;
    localparam int NUMW = NW + 1;
    localparam int QB   = max2(W + 1, F + 11) + 1;
    localparam int SXW  = QB + 2;

    localparam logic [KW-1:0]          K_FOCAL = KW'(FOCAL << F);
    localparam logic signed [SUMW-1:0] HALF_U  = SUMW'(1) << (UNIT_BITS - 1);
    localparam logic signed [SXW-1:0]  CX      = SXW'(CENTER_X << F);
    localparam logic signed [SXW-1:0]  CY      = SXW'(CENTER_Y << F);
    localparam logic signed [SXW-1:0]  SAT_HI  = SXW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SXW-1:0]  SAT_LO  = -SAT_HI - SXW'(1);

    logic [2:0][W-1:0] r_cam;
    logic [2:0][W-1:0] r_look;
    logic              w_start;
    t_basis            w_basis;
    logic              w_en;
    logic              w_in_acc;

    logic                   r1_vld;
    logic signed [RELW-1:0] r1_rel [3];
    logic                   r2_vld;
    logic signed [PW-1:0]   r2_prod [3][3];
    logic                   r3_vld;
    logic signed [VW-1:0]   r3_v [3];
    logic                   r4_vld;
    logic [NW-1:0]          r4_nx, r4_ny;
    logic [VW-1:0]          r4_den;
    t_tag                   r4_tag;
    logic                   r5_vld;
    logic [NUMW-1:0]        r5_nx, r5_ny;
    logic [VW-1:0]          r5_den;
    t_tag                   r5_tag;

    logic                   w_dv_vld;
    logic [QB-1:0]          w_q_x, w_q_y;
    t_tag                   w_dv_tag;

    logic                   r_out_vld;
    logic [W-1:0]           r_sx, r_sy;
    t_status                r_st;

    logic signed [SUMW-1:0] w_sum [3];
    logic [VW-1:0]          w_vxm, w_vym, w_vzm;
    logic signed [SXW-1:0]  w_qxs, w_qys, w_sx, w_sy;
    logic                   w_clamp;
    logic [W-1:0]           w_sx_sat, w_sy_sat;
    t_status                w_st;

    // Config registers
    assign w_start = i_cfg_we && (i_cfg_idx <= REG_LOOK_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam  <= {W'(800 << F), W'(0), W'(0)};
            r_look <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CAM_X:  r_cam[0]  <= i_cfg_data;
                REG_CAM_Y:  r_cam[1]  <= i_cfg_data;
                REG_CAM_Z:  r_cam[2]  <= i_cfg_data;
                REG_LOOK_X: r_look[0] <= i_cfg_data;
                REG_LOOK_Y: r_look[1] <= i_cfg_data;
                REG_LOOK_Z: r_look[2] <= i_cfg_data;
                default:    r_look    <= r_look;
            endcase
        end
    end

    lmp_basis #(.COORD_WIDTH(W)) u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cam   (r_cam),
        .i_look  (r_look),
        .o_basis (w_basis)
    );

    // Global stall: the pipeline moves when the output register can take a word
    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en && w_basis.ready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_in_acc;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // Dot sums and magnitudes
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum[j] = SUMW'(r2_prod[j][0]) + SUMW'(r2_prod[j][1]) + SUMW'(r2_prod[j][2]);
        end
        w_vxm = r3_v[0][VW-1] ? VW'(-r3_v[0]) : VW'(r3_v[0]);
        w_vym = r3_v[1][VW-1] ? VW'(-r3_v[1]) : VW'(r3_v[1]);
        w_vzm = r3_v[2][VW-1] ? VW'(-r3_v[2]) : VW'(r3_v[2]);
    end

    // Front stages: offset, basis products, rounded dots, focal scale, bias
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_rel[i] <= $signed({i_s_axis_tdata[i*W+W-1], i_s_axis_tdata[i*W +: W]})
                           - $signed({r_cam[i][W-1], r_cam[i]});
            end
            for (int i = 0; i < 3; i++) begin
                r2_prod[0][i] <= r1_rel[i] * $signed(w_basis.r[i]);
                r2_prod[1][i] <= r1_rel[i] * $signed(w_basis.u[i]);
                r2_prod[2][i] <= r1_rel[i] * $signed(w_basis.f[i]);
            end
            for (int j = 0; j < 3; j++) begin
                r3_v[j] <= VW'((w_sum[j] + HALF_U) >>> UNIT_BITS);
            end
            r4_nx        <= NW'(w_vxm) * NW'(K_FOCAL);
            r4_ny        <= NW'(w_vym) * NW'(K_FOCAL);
            r4_den       <= w_vzm;
            r4_tag.neg_x <= r3_v[0][VW-1] ^ r3_v[2][VW-1];
            r4_tag.neg_y <= r3_v[1][VW-1] ^ r3_v[2][VW-1];
            r4_tag.zero  <= (r3_v[2] == '0);
            r5_nx        <= NUMW'(r4_nx) + NUMW'(r4_den >> 1);
            r5_ny        <= NUMW'(r4_ny) + NUMW'(r4_den >> 1);
            r5_den       <= r4_den;
            r5_tag       <= r4_tag;
        end
    end

    lmp_div #(.NUMW(NUMW), .DENW(VW), .QB(QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r5_vld),
        .i_num_x (r5_nx),
        .i_num_y (r5_ny),
        .i_den   (r5_den),
        .i_tag   (r5_tag),
        .o_vld   (w_dv_vld),
        .o_q_x   (w_q_x),
        .o_q_y   (w_q_y),
        .o_tag   (w_dv_tag)
    );

    // Offset from center, clamp, status
    always_comb begin
        w_qxs = $signed({2'b00, w_q_x});
        w_qys = $signed({2'b00, w_q_y});
        if (w_dv_tag.neg_x) w_qxs = -w_qxs;
        if (w_dv_tag.neg_y) w_qys = -w_qys;
        if (w_basis.degen || w_dv_tag.zero) begin
            w_sx = CX;
            w_sy = CY;
        end else begin
            w_sx = CX + w_qxs;
            w_sy = CY - w_qys;
        end
        w_clamp = 1'b0;
        if (w_sx > SAT_HI) begin
            w_sx_sat = W'(SAT_HI);
            w_clamp  = 1'b1;
        end else if (w_sx < SAT_LO) begin
            w_sx_sat = W'(SAT_LO);
            w_clamp  = 1'b1;
        end else begin
            w_sx_sat = W'(w_sx);
        end
        if (w_sy > SAT_HI) begin
            w_sy_sat = W'(SAT_HI);
            w_clamp  = 1'b1;
        end else if (w_sy < SAT_LO) begin
            w_sy_sat = W'(SAT_LO);
            w_clamp  = 1'b1;
        end else begin
            w_sy_sat = W'(w_sy);
        end
        priority if (w_basis.degen) w_st = ST_DEGEN;
        else if (w_dv_tag.zero)     w_st = ST_ZERO;
        else if (w_clamp)           w_st = ST_SAT;
        else                        w_st = ST_OK;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx <= w_sx_sat;
            r_sy <= w_sy_sat;
            r_st <= w_st;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = TDO'({r_sy, r_sx});
    assign o_m_axis_tuser  = r_st;

endmodule

// ----- rtl/lmp_chk.sv -----
// Port-level checker for the projection block, bound to the top level.
module lmp_chk import lmp_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic [((3*W+7)/8)*8-1:0]     i_s_axis_tdata,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [((2*W+7)/8)*8-1:0]     o_m_axis_tdata,
    input t_status                      o_m_axis_tuser,
    input logic                         i_cfg_we,
    input t_reg_idx                     i_cfg_idx,
    input logic [W-1:0]                 i_cfg_data
);

    localparam logic [W-1:0] CX_SAT = W'(center_sat(W, F, CENTER_X));

    // Reset empties the output and blocks input while the basis rebuilds
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("output valid or input ready after reset");

    // A register write drops input ready for the rebuild
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx <= REG_LOOK_Z) |=> !o_s_axis_tready)
        else $error("input ready right after a register write");

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed under stall");

    // Zero depth and degenerate camera report the screen center in x
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_ZERO || o_m_axis_tuser == ST_DEGEN) |->
            o_m_axis_tdata[W-1:0] == CX_SAT)
        else $error("special status without screen center");

endmodule

bind lookat_perspective_project lmp_chk #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_lmp_chk (.*);
